// File: src/avk_pkg.sv
// Package for the autokey Vigenere encryptor: item and result types,
// configuration register codes and character constants.
// No dependencies.
`timescale 1ns / 1ps

package avk_pkg;

  localparam int CHAR_W     = 8;
  localparam int LETTER_W   = 5;
  localparam int KEY_BITS   = 60;
  localparam int KEY_LEN_W  = 4;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CHAR_W-1:0]   CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0]   CHAR_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0]   SPACE_CHAR = 8'h20;
  localparam logic [LETTER_W:0]   ALPHA      = 6'd26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LETTERS = 1'b0,
    CFG_KEY_LENGTH  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              message_start;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              was_letter;
  } result_t;

endpackage

// File: src/avk_in_stage.sv
// Input register of the autokey Vigenere encryptor.
// Depends on avk_pkg for the item type.
`timescale 1ns / 1ps

module avk_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [avk_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] char_in
  input  logic                        s_tuser,   // [0] message_start
  input  logic                        advance,
  output logic                        item_valid,
  output avk_pkg::item_t              item
);
  import avk_pkg::*;

  // The stage takes a new transfer when it is empty or its item moves on.
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.char_in       <= s_tdata;
      item.message_start <= s_tuser;
    end
  end

endmodule

// File: src/avk_cipher.sv
// Keystream state and cipher arithmetic of the autokey Vigenere encryptor.
// Holds the plaintext history ring, ring position and key-consumed flag.
// Depends on avk_pkg for types and constants.
`timescale 1ns / 1ps

module avk_cipher #(
  parameter int KEY_MAX = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  avk_pkg::item_t                item,
  input  logic [avk_pkg::KEY_BITS-1:0]  key_letters,
  input  logic [avk_pkg::KEY_LEN_W-1:0] key_length,
  output avk_pkg::result_t              result
);
  import avk_pkg::*;

  localparam int IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  logic [LETTER_W-1:0]  plain_history [KEY_MAX];
  logic [KEY_LEN_W-1:0] ring_position;
  logic                 key_used_up;
  logic [KEY_LEN_W-1:0] ring_position_next;
  logic                 key_used_up_next;

  logic                 is_letter;
  logic [KEY_LEN_W-1:0] eff_len;
  logic [KEY_LEN_W-1:0] start_pos;
  logic                 start_used;
  logic [IDX_W-1:0]     pos_idx;
  logic [5:0]           key_off;
  logic [LETTER_W-1:0]  key_raw;
  logic [LETTER_W-1:0]  key_val;
  logic [LETTER_W-1:0]  hist_val;
  logic [LETTER_W-1:0]  stream_val;
  logic [LETTER_W-1:0]  plain_val;
  logic [LETTER_W:0]    sum;
  logic [LETTER_W:0]    sum_mod;
  logic [KEY_LEN_W-1:0] pos_inc;

  always_comb begin
    is_letter = (item.char_in >= CHAR_A) && (item.char_in <= CHAR_Z);

    if (key_length == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length > KEY_LEN_W'(KEY_MAX)) begin
      eff_len = KEY_LEN_W'(KEY_MAX);
    end else begin
      eff_len = key_length;
    end

    // A message start restarts the keystream before this byte is used.
    start_pos  = item.message_start ? '0 : ring_position;
    start_used = item.message_start ? 1'b0 : key_used_up;

    if (start_pos >= KEY_LEN_W'(KEY_MAX)) begin
      pos_idx = '0;
    end else begin
      pos_idx = start_pos[IDX_W-1:0];
    end

    key_off = 6'(pos_idx) * 6'(LETTER_W);
    key_raw = key_letters[key_off +: LETTER_W];
    key_val = ({1'b0, key_raw} >= ALPHA) ? LETTER_W'({1'b0, key_raw} - ALPHA) : key_raw;
    hist_val   = plain_history[pos_idx];
    stream_val = start_used ? hist_val : key_val;

    plain_val = LETTER_W'(item.char_in - CHAR_A);
    sum       = {1'b0, plain_val} + {1'b0, stream_val};
    sum_mod   = (sum >= ALPHA) ? sum - ALPHA : sum;

    if (is_letter) begin
      result.char_out   = CHAR_A + CHAR_W'(sum_mod);
      result.was_letter = 1'b1;
    end else begin
      result.char_out   = SPACE_CHAR;
      result.was_letter = 1'b0;
    end

    pos_inc = KEY_LEN_W'(pos_idx) + KEY_LEN_W'(1);
    ring_position_next = start_pos;
    key_used_up_next   = start_used;
    if (is_letter) begin
      if (pos_inc >= eff_len) begin
        ring_position_next = '0;
        key_used_up_next   = 1'b1;
      end else begin
        ring_position_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_position <= '0;
      key_used_up   <= 1'b0;
    end else if (fire) begin
      ring_position <= ring_position_next;
      key_used_up   <= key_used_up_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_letter) begin
      plain_history[pos_idx] <= plain_val;
    end
  end

  // The ring position never leaves the ring.
  a_pos_in_ring: assert property (@(posedge clk) disable iff (rst)
    ring_position < KEY_LEN_W'(KEY_MAX))
    else $error("ring position outside the history ring");

  // A letter always moves the keystream on: it advances or wraps into autokey mode.
  a_letter_advances: assert property (@(posedge clk) disable iff (rst)
    fire && is_letter |=> key_used_up || (ring_position != '0))
    else $error("letter did not advance the keystream");

  // Other bytes without a message start leave the keystream alone.
  a_other_holds: assert property (@(posedge clk) disable iff (rst)
    fire && !is_letter && !item.message_start |=>
      $stable(ring_position) && $stable(key_used_up))
    else $error("non-letter byte changed the keystream");

  // Results are an uppercase letter or a space, matching the letter flag.
  a_result_code: assert property (@(posedge clk) disable iff (rst)
    fire |-> (result.was_letter && result.char_out >= CHAR_A && result.char_out <= CHAR_Z)
          || (!result.was_letter && result.char_out == SPACE_CHAR))
    else $error("result byte does not match its letter flag");

endmodule

// File: src/autokey_vigenere_encrypt.sv
// A transfer passes the input register (avk_in_stage), then the output register.
// One byte per cycle unless the output stalls; the ring position and history update
// in the same cycle that a byte is enciphered, so the next byte follows directly.
// Reset (rst, synchronous) clears the keystream position, the key-consumed
// flag, the key letters and sets the key length to one; history needs no reset.
// Top level of the autokey Vigenere encryptor; uses avk_pkg, avk_in_stage, avk_cipher.
`timescale 1ns / 1ps

module autokey_vigenere_encrypt #(
  parameter int KEY_MAX = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [avk_pkg::CHAR_W-1:0]    s_tdata,    // [7:0] char_in
  input  logic                          s_tuser,    // [0] message_start
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [avk_pkg::CHAR_W-1:0]    m_tdata,    // [7:0] char_out
  output logic                          m_tuser,    // [0] was_letter
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [avk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [avk_pkg::KEY_BITS-1:0]  cfg_data
);
  import avk_pkg::*;

  logic [KEY_BITS-1:0]  key_letters;
  logic [KEY_LEN_W-1:0] key_length;
  logic                 item_valid;
  item_t                item;
  result_t              result;
  logic                 advance;
  logic                 fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_letters <= '0;
      key_length  <= KEY_LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KEY_LETTERS: key_letters <= cfg_data;
        CFG_KEY_LENGTH:  key_length  <= cfg_data[KEY_LEN_W-1:0];
        default:         ;
      endcase
    end
  end

  // The output register takes a new result when it is empty or being drained.
  assign advance = !m_tvalid || m_tready;
  assign fire    = item_valid && advance;

  avk_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  avk_cipher #(
    .KEY_MAX (KEY_MAX)
  ) u_cipher (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item),
    .key_letters (key_letters),
    .key_length  (key_length),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= result.char_out;
      m_tuser <= result.was_letter;
    end
  end

endmodule
